[hdl/i2cm_pkg.sv]
// Shared types and constants for the I2C master bit engine.
// No dependencies; imported by every module of the engine.
`default_nettype none

package i2cm_pkg;

   // Command codes carried on the request side
   typedef enum logic [2:0] {
      CMD_TICK   = 3'd0,
      CMD_START  = 3'd1,
      CMD_RSTART = 3'd2,
      CMD_STOP   = 3'd3,
      CMD_WRITE  = 3'd4,
      CMD_READ   = 3'd5
   } cmd_type;

   localparam int unsigned BITS_PER_BYTE = 8;
   localparam int unsigned PHASE_W       = 5;
   localparam logic [7:0]  MSB_MASK      = 8'h80;

   // Phase index of the first half period after the data bits
   localparam logic [PHASE_W-1:0] DATA_END  = PHASE_W'(2 * BITS_PER_BYTE);
   // Phase whose end samples the slave ACK on a write
   localparam logic [PHASE_W-1:0] ACK_PHASE = PHASE_W'(2 * BITS_PER_BYTE + 1);

   // Request beat layout
   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned REQ_USER_W = 3;
   localparam int unsigned RSP_DATA_W = 16;

   // Classified item held in the queue between front and back
   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] tx_byte;
      logic       send_ack;
      logic       sda_in;
   } queue_item_type;

   // Result beat, packed so that scl_release is bit 0
   typedef struct packed {
      logic [1:0] pad;
      logic       rejected;
      logic       busy_res;
      logic       ack_level;
      logic [7:0] rx_byte;
      logic       done_res;
      logic       sda_release;
      logic       scl_release;
   } result_type;

   // Pin levels for one half period
   typedef struct packed {
      logic scl;
      logic sda;
   } pins_type;

endpackage

`default_nettype wire

[hdl/i2cm_front.sv]
// Front end: takes request beats, decodes the command and builds queue items.
// Depends on i2cm_pkg.
`default_nettype none

module i2cm_front (
   input  wire logic                             queue_full,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [i2cm_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire logic [i2cm_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                                  push_valid,
   output i2cm_pkg::queue_item_type              push_item
);
   import i2cm_pkg::*;

   cmd_type cmd_dec;

   // Fold unknown codes into a plain tick
   always_comb begin
      unique case (req_tuser)
         CMD_START, CMD_RSTART, CMD_STOP, CMD_WRITE, CMD_READ: begin
            cmd_dec = cmd_type'(req_tuser);
         end
         default: begin
            cmd_dec = CMD_TICK;
         end
      endcase
   end

   // Accept whenever the queue has room
   assign req_tready = ~queue_full;
   assign push_valid = req_tvalid & ~queue_full;

   assign push_item.cmd      = cmd_dec;
   assign push_item.tx_byte  = req_tdata[7:0];
   assign push_item.send_ack = req_tdata[8];
   assign push_item.sda_in   = req_tdata[9];

   // Upper request bits are padding and are not used
   logic unused_pad;
   assign unused_pad = ^req_tdata[REQ_DATA_W-1:10];

endmodule

`default_nettype wire

[hdl/i2cm_queue.sv]
// Short FIFO that decouples the decode front from the bit sequencer.
// Depends on i2cm_pkg for the item type.
`default_nettype none

module i2cm_queue #(
   parameter int unsigned DEPTH = 4
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push_valid,
   input  wire i2cm_pkg::queue_item_type  push_item,
   output logic                           full,
   output logic                           pop_valid,
   input  wire logic                      pop_ready,
   output i2cm_pkg::queue_item_type       pop_item
);
   import i2cm_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   queue_item_type   mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == FULL_CNT);
   assign pop_valid = (count_ff != '0);
   assign pop_item  = mem_ff[rd_ptr_ff];
   assign do_push   = push_valid & ~full;
   assign do_pop    = pop_valid & pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

[hdl/i2cm_back.sv]
// Back end: runs the start/stop/byte half-period sequences and registers results.
// Depends on i2cm_pkg.
`default_nettype none

module i2cm_back (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             q_valid,
   output logic                                  q_pop,
   input  wire i2cm_pkg::queue_item_type         q_item,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [i2cm_pkg::RSP_DATA_W-1:0]       rsp_tdata
);
   import i2cm_pkg::*;

   // Number of half periods in each sequence
   function automatic logic [PHASE_W-1:0] seq_len(input cmd_type cmd);
      logic [PHASE_W-1:0] n;
      unique case (cmd)
         CMD_START:  n = PHASE_W'(4);
         CMD_RSTART: n = PHASE_W'(8);
         CMD_STOP:   n = PHASE_W'(3);
         CMD_WRITE:  n = PHASE_W'(2 * BITS_PER_BYTE + 2);
         CMD_READ:   n = PHASE_W'(2 * BITS_PER_BYTE + 3);
         default:    n = '0;
      endcase
      return n;
   endfunction

   // Pin levels held during phase p of a sequence
   function automatic pins_type enter_phase(input cmd_type cmd,
                                            input logic [PHASE_W-1:0] p,
                                            input pins_type cur,
                                            input logic data_bit,
                                            input logic ack_sel);
      pins_type o;
      logic     low_or_keep;
      logic     a;
      low_or_keep = (p == '0) ? cur.scl : 1'b0;
      a           = ~ack_sel;
      o           = cur;
      unique case (cmd)
         CMD_START: begin
            if (p == PHASE_W'(0))      o = '{cur.scl, 1'b1};
            else if (p == PHASE_W'(1)) o = '{1'b1, 1'b1};
            else if (p == PHASE_W'(2)) o = '{1'b1, 1'b0};
            else                       o = '{1'b0, 1'b0};
         end
         CMD_RSTART: begin
            if (p <= PHASE_W'(1))      o = '{cur.scl, 1'b0};
            else if (p == PHASE_W'(2)) o = '{1'b1, 1'b0};
            else if (p <= PHASE_W'(5)) o = '{1'b1, 1'b1};
            else if (p == PHASE_W'(6)) o = '{1'b1, 1'b0};
            else                       o = '{1'b0, 1'b0};
         end
         CMD_STOP: begin
            if (p == PHASE_W'(0))      o = '{cur.scl, 1'b0};
            else if (p == PHASE_W'(1)) o = '{1'b1, 1'b0};
            else                       o = '{1'b1, 1'b1};
         end
         CMD_WRITE: begin
            if (p < DATA_END)          o = '{p[0] ? 1'b1 : low_or_keep, data_bit};
            else if (p == DATA_END)    o = '{1'b0, 1'b1};
            else                       o = '{1'b1, 1'b1};
         end
         CMD_READ: begin
            if (p < DATA_END)          o = '{p[0] ? 1'b1 : low_or_keep, 1'b1};
            else if (p == DATA_END)    o = '{1'b0, a};
            else if (p == ACK_PHASE)   o = '{1'b1, a};
            else                       o = '{1'b0, 1'b1};
         end
         default: begin
            o = cur;
         end
      endcase
      return o;
   endfunction

   // Engine state
   cmd_type            act_ff, act_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [7:0]         shift_ff, shift_in;
   logic               ackc_ff, ackc_in;
   pins_type           pins_ff, pins_in;
   logic               acks_ff, acks_in;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;

   logic               busy;
   logic [PHASE_W-1:0] p_next;
   logic               done, rej;
   logic [7:0]         rx;
   logic [7:0]         shift_new;

   assign busy  = (act_ff != CMD_TICK);
   assign q_pop = q_valid & (~rsp_valid_ff | rsp_tready);

   // Step the sequencer for one popped item
   always_comb begin
      act_in    = act_ff;
      phase_in  = phase_ff;
      shift_in  = shift_ff;
      ackc_in   = ackc_ff;
      pins_in   = pins_ff;
      acks_in   = acks_ff;
      done      = 1'b0;
      rej       = 1'b0;
      rx        = '0;
      shift_new = '0;
      p_next    = phase_ff + 1'b1;
      if (q_item.cmd != CMD_TICK) begin
         if (busy) begin
            rej = 1'b1;
         end else begin
            shift_new = (q_item.cmd == CMD_WRITE) ? q_item.tx_byte : 8'h00;
            act_in    = q_item.cmd;
            phase_in  = '0;
            shift_in  = shift_new;
            ackc_in   = (q_item.cmd == CMD_READ) ? q_item.send_ack : 1'b0;
            pins_in   = enter_phase(q_item.cmd, '0, pins_ff,
                                    |(shift_new & MSB_MASK), ackc_in);
         end
      end else if (busy) begin
         shift_new = shift_ff;
         if (act_ff == CMD_WRITE) begin
            if (phase_ff < DATA_END && phase_ff[0]) begin
               shift_new = {shift_ff[6:0], 1'b0};
            end else if (phase_ff == ACK_PHASE) begin
               acks_in = q_item.sda_in;
            end
         end else if (act_ff == CMD_READ) begin
            if (phase_ff < DATA_END && phase_ff[0]) begin
               shift_new = {shift_ff[6:0], q_item.sda_in};
            end
         end
         shift_in = shift_new;
         if (p_next >= seq_len(act_ff)) begin
            done     = 1'b1;
            rx       = (act_ff == CMD_READ) ? shift_new : 8'h00;
            act_in   = CMD_TICK;
            phase_in = '0;
            case (act_ff)
               CMD_STOP:               pins_in = '{1'b1, 1'b1};
               CMD_WRITE, CMD_READ:    pins_in = '{1'b0, 1'b1};
               default:                pins_in = '{1'b0, 1'b0};
            endcase
         end else begin
            phase_in = p_next;
            pins_in  = enter_phase(act_ff, p_next, pins_ff,
                                   |(shift_new & MSB_MASK), ackc_ff);
         end
      end
   end

   // Build the result beat
   always_comb begin
      rsp_in.pad         = '0;
      rsp_in.rejected    = rej;
      rsp_in.busy_res    = (act_in != CMD_TICK);
      rsp_in.ack_level   = acks_in;
      rsp_in.rx_byte     = rx;
      rsp_in.done_res    = done;
      rsp_in.sda_release = pins_in.sda;
      rsp_in.scl_release = pins_in.scl;
      if (q_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff       <= CMD_TICK;
         phase_ff     <= '0;
         shift_ff     <= '0;
         ackc_ff      <= 1'b0;
         pins_ff      <= '{1'b1, 1'b1};
         acks_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            act_ff   <= act_in;
            phase_ff <= phase_in;
            shift_ff <= shift_in;
            ackc_ff  <= ackc_in;
            pins_ff  <= pins_in;
            acks_ff  <= acks_in;
         end
      end
   end

   // Result payload, no reset needed
   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_ff);

`ifndef NO_ASSERTIONS
   // A finished command leaves the engine idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.done_res |-> !rsp_ff.busy_res && !busy)
      else $error("done reported while engine still busy");

   // A rejected command leaves the engine busy and never reports done
   a_rej_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.rejected |-> rsp_ff.busy_res && !rsp_ff.done_res)
      else $error("rejected beat with inconsistent busy or done");

   // Idle engine keeps the phase counter cleared
   a_idle_phase: assert property (@(posedge clock) disable iff (reset)
      !busy |-> phase_ff == '0)
      else $error("phase count nonzero while idle");

   // State only moves when an item is popped
   a_hold_state: assert property (@(posedge clock) disable iff (reset)
      !q_pop |=> $stable(phase_ff) && $stable(shift_ff) && $stable(pins_ff))
      else $error("engine state changed without a popped item");
`endif

endmodule

`default_nettype wire

[hdl/i2c_master_bit_engine.sv]
// Top level of the I2C master bit engine: decode front, item queue, bit sequencer.
// Depends on i2cm_pkg, i2cm_front, i2cm_queue and i2cm_back.
//
//   channel  dir  handshake            payload
//   req_     in   req_tvalid/tready    tuser: command; tdata: tx_byte, send_ack, sda_in
//   rsp_     out  rsp_tvalid/tready    tdata: scl/sda release, done, rx_byte, ack, busy, rej
//
// One request beat is accepted per clock while the queue has room; each one yields
// exactly one response beat. An accepted beat is written into the queue; once popped,
// it steps the sequencer and its result is registered in the response register.
// The queue holds up to QUEUE_DEPTH beats while the response side stalls; ready drops
// only when it is full. Reset is synchronous and leaves both pins released, idle.
`default_nettype none

module i2c_master_bit_engine #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [7:0] tx_byte, [8] send_ack, [9] sda_in, [15:10] zero
   input  wire logic [i2cm_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [2:0] command
   input  wire logic [i2cm_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [0] scl_release, [1] sda_release, [2] done_res, [10:3] rx_byte,
   // [11] ack_level, [12] busy_res, [13] rejected, [15:14] zero
   output logic [i2cm_pkg::RSP_DATA_W-1:0]        rsp_tdata
);
   import i2cm_pkg::*;

   logic           queue_full;
   logic           push_valid;
   queue_item_type push_item;
   logic           pop_valid;
   logic           pop_ready;
   queue_item_type pop_item;

   i2cm_front u_front (
      .queue_full (queue_full),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   i2cm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   i2cm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (pop_valid),
      .q_pop      (pop_ready),
      .q_item     (pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

[verif/tb.sv]
// Self-checking bench for i2c_master_bit_engine: directed table, then random command runs.
// Each accepted beat is predicted by a local model or pinned by the table, then checked.
// Depends on i2cm_pkg and the RTL of the engine.
`timescale 1ns / 1ps

module tb;
   import i2cm_pkg::*;

   // Codes 6 and 7 are not commands; the engine treats them as ticks
   localparam logic [2:0] CMD_SPARE_A = 3'd6;
   localparam logic [2:0] CMD_SPARE_B = 3'd7;

   localparam int unsigned DIRECTED_ROWS = 15;
   localparam int unsigned RANDOM_ITEMS  = 400;
   localparam int unsigned DRAIN_CYCLES  = 16;
   // Slowest legal stretch without a beat is the long receiver hold plus a sender gap;
   // the limit sits far above that.
   localparam int unsigned STALL_LIMIT   = 2000;

   // Receiver pacing modes
   localparam int unsigned PACE_FREE  = 0;
   localparam int unsigned PACE_COIN  = 1;
   localparam int unsigned PACE_THIRD = 2;
   localparam int unsigned PACE_HOLD  = 3;

   typedef struct {
      logic [2:0]  code;
      logic [7:0]  tx;
      logic        sack;
      logic        sda;
      int unsigned reps;
      bit          fixed;
      result_type  want;
   } stim_row_type;

   typedef struct {
      bit         fixed;
      result_type want;
   } pinned_levels_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [7:0] tx_byte, [8] send_ack, [9] sda_in, [15:10] zero
   logic [2:0]  req_tuser  = '0;   // [2:0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [0] scl, [1] sda, [2] done, [10:3] rx, [11] ack,
                                   // [12] busy, [13] rejected, [15:14] zero

   // Engine model state
   cmd_type     run_cmd       = CMD_TICK;
   logic [4:0]  run_phase     = '0;
   logic [7:0]  run_shift     = '0;
   logic        run_ack_drive = 1'b0;
   logic        pin_scl       = 1'b1;
   logic        pin_sda       = 1'b1;
   logic        last_ack      = 1'b1;

   pinned_levels_type table_levels_q[$];
   result_type        levels_due_q[$];
   int unsigned       fault_count = 0;
   int unsigned       rsp_count   = 0;
   int unsigned       idle_cycles = 0;
   int unsigned       burst_left  = 0;
   int unsigned       items_sent  = 0;

   stim_row_type plan [DIRECTED_ROWS];

   i2c_master_bit_engine dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Half periods in each command sequence
   function automatic int unsigned half_periods(cmd_type c);
      case (c)
         CMD_START:  return 4;
         CMD_RSTART: return 8;
         CMD_STOP:   return 3;
         CMD_WRITE:  return 18;
         CMD_READ:   return 19;
         default:    return 0;
      endcase
   endfunction

   function automatic result_type mk_rsp(logic scl, logic sda, logic done, logic [7:0] rx,
                                         logic ack, logic busy, logic rej);
      result_type r;
      r             = '0;
      r.scl_release = scl;
      r.sda_release = sda;
      r.done_res    = done;
      r.rx_byte     = rx;
      r.ack_level   = ack;
      r.busy_res    = busy;
      r.rejected    = rej;
      return r;
   endfunction

   function automatic stim_row_type mk_row(logic [2:0] code, logic [7:0] tx, logic sack,
                                           logic sda, int unsigned reps, bit fixed,
                                           result_type want);
      stim_row_type s;
      s.code  = code;
      s.tx    = tx;
      s.sack  = sack;
      s.sda   = sda;
      s.reps  = reps;
      s.fixed = fixed;
      s.want  = want;
      return s;
   endfunction

   // Set the pin levels held during phase p of the running command
   task automatic hold_levels(input logic [4:0] p);
      logic keep;
      logic low_keep;
      logic ack_bit;
      keep     = pin_scl;
      low_keep = (p == '0) ? keep : 1'b0;
      ack_bit  = ~run_ack_drive;
      case (run_cmd)
         CMD_START: begin
            if (p == 5'd0)      {pin_scl, pin_sda} = {keep, 1'b1};
            else if (p == 5'd1) {pin_scl, pin_sda} = 2'b11;
            else if (p == 5'd2) {pin_scl, pin_sda} = 2'b10;
            else                {pin_scl, pin_sda} = 2'b00;
         end
         CMD_RSTART: begin
            if (p <= 5'd1)      {pin_scl, pin_sda} = {keep, 1'b0};
            else if (p == 5'd2) {pin_scl, pin_sda} = 2'b10;
            else if (p <= 5'd5) {pin_scl, pin_sda} = 2'b11;
            else if (p == 5'd6) {pin_scl, pin_sda} = 2'b10;
            else                {pin_scl, pin_sda} = 2'b00;
         end
         CMD_STOP: begin
            if (p == 5'd0)      {pin_scl, pin_sda} = {keep, 1'b0};
            else if (p == 5'd1) {pin_scl, pin_sda} = 2'b10;
            else                {pin_scl, pin_sda} = 2'b11;
         end
         CMD_WRITE: begin
            if (p < DATA_END)
               {pin_scl, pin_sda} = {p[0] ? 1'b1 : low_keep, (run_shift & MSB_MASK) != '0};
            else if (p == DATA_END)
               {pin_scl, pin_sda} = 2'b01;
            else
               {pin_scl, pin_sda} = 2'b11;
         end
         CMD_READ: begin
            if (p < DATA_END)        {pin_scl, pin_sda} = {p[0] ? 1'b1 : low_keep, 1'b1};
            else if (p == DATA_END)  {pin_scl, pin_sda} = {1'b0, ack_bit};
            else if (p == ACK_PHASE) {pin_scl, pin_sda} = {1'b1, ack_bit};
            else                     {pin_scl, pin_sda} = 2'b01;
         end
         default: ;
      endcase
   endtask

   // Advance the engine model by one request beat and give the beat it answers with
   task automatic advance_engine(input logic [2:0] code, input logic [7:0] tx,
                                 input logic sack, input logic sda, output result_type r);
      cmd_type    c;
      logic       busy;
      logic [4:0] p;
      logic       done;
      logic       rej;
      logic [7:0] rx;
      busy = (run_cmd != CMD_TICK);
      c    = (code > CMD_READ) ? CMD_TICK : cmd_type'(code);
      done = 1'b0;
      rej  = 1'b0;
      rx   = '0;
      if (c != CMD_TICK) begin
         if (busy) begin
            rej = 1'b1;
         end else begin
            run_cmd       = c;
            run_phase     = '0;
            run_shift     = (c == CMD_WRITE) ? tx : 8'h00;
            run_ack_drive = (c == CMD_READ) ? sack : 1'b0;
            hold_levels('0);
         end
      end else if (busy) begin
         p = run_phase;
         if (run_cmd == CMD_WRITE) begin
            if (p < DATA_END && p[0]) run_shift = {run_shift[6:0], 1'b0};
            else if (p == ACK_PHASE)  last_ack = sda;
         end else if (run_cmd == CMD_READ && p < DATA_END && p[0]) begin
            run_shift = {run_shift[6:0], sda};
         end
         p = p + 1'b1;
         if (p >= half_periods(run_cmd)) begin
            done = 1'b1;
            if (run_cmd == CMD_READ) rx = run_shift;
            case (run_cmd)
               CMD_START, CMD_RSTART: {pin_scl, pin_sda} = 2'b00;
               CMD_STOP:              {pin_scl, pin_sda} = 2'b11;
               default:               {pin_scl, pin_sda} = 2'b01;
            endcase
            run_cmd   = CMD_TICK;
            run_phase = '0;
         end else begin
            run_phase = p;
            hold_levels(p);
         end
      end
      r = mk_rsp(pin_scl, pin_sda, done, rx, last_ack, run_cmd != CMD_TICK, rej);
   endtask

   task automatic note_fault(input string why, input result_type want, input result_type got);
      fault_count++;
      if (fault_count <= 10) begin
         $display("%0t %s: want scl=%b sda=%b done=%b rx=%h ack=%b busy=%b rej=%b",
                  $time, why, want.scl_release, want.sda_release, want.done_res,
                  want.rx_byte, want.ack_level, want.busy_res, want.rejected);
         $display("      got  scl=%b sda=%b done=%b rx=%h ack=%b busy=%b rej=%b",
                  got.scl_release, got.sda_release, got.done_res, got.rx_byte,
                  got.ack_level, got.busy_res, got.rejected);
      end
   endtask

   // Offer one request beat, opening a new burst after a random gap when due
   task automatic offer(input logic [2:0] code, input logic [7:0] tx, input logic sack,
                        input logic sda, input bit fixed, input result_type want);
      pinned_levels_type e;
      int unsigned       gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 32);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      e.fixed = fixed;
      e.want  = want;
      table_levels_q.push_back(e);
      req_tvalid <= 1'b1;
      req_tuser  <= code;
      req_tdata  <= {6'd0, sda, sack, tx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // Tick beat with random content; now and then a spare code stands in for the tick
   task automatic offer_tick();
      logic [2:0] code;
      code = CMD_TICK;
      if ($urandom_range(0, 9) == 0) code = $urandom_range(0, 1) ? CMD_SPARE_B : CMD_SPARE_A;
      offer(code, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
            1'($urandom_range(0, 1)), 1'b0, '0);
   endtask

   // Predict on request beats, check on response beats
   always @(posedge clock) begin : watch_beats
      pinned_levels_type e;
      result_type        calc;
      result_type        got;
      result_type        want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            advance_engine(req_tuser, req_tdata[7:0], req_tdata[8], req_tdata[9], calc);
            e = table_levels_q.pop_front();
            levels_due_q.push_back(e.fixed ? e.want : calc);
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            got = result_type'(rsp_tdata);
            if (levels_due_q.size() == 0) begin
               note_fault("beat with nothing pending", '0, got);
            end else begin
               want = levels_due_q.pop_front();
               if (got.scl_release !== want.scl_release ||
                   got.sda_release !== want.sda_release ||
                   got.done_res !== want.done_res || got.rx_byte !== want.rx_byte ||
                   got.ack_level !== want.ack_level || got.busy_res !== want.busy_res ||
                   got.rejected !== want.rejected)
                  note_fault("mismatch", want, got);
            end
         end
      end
   end

   // Watchdog: end the run when no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Receiver: segments of free flow, coin flips and a one-in-three pattern,
   // plus one long hold so the queue fills and the request side stalls
   initial begin : rsp_pace
      int unsigned mode;
      int unsigned span;
      int unsigned third;
      bit          held;
      held  = 1'b0;
      third = 0;
      @(negedge reset);
      forever begin
         if (!held && rsp_count >= 120) begin
            mode = PACE_HOLD;
            span = 60;
            held = 1'b1;
         end else begin
            mode = $urandom_range(PACE_FREE, PACE_THIRD);
            span = $urandom_range(8, 48);
         end
         repeat (span) begin
            @(posedge clock);
            third = (third + 1) % 3;
            case (mode)
               PACE_FREE:  rsp_tready <= 1'b1;
               PACE_COIN:  rsp_tready <= 1'($urandom_range(0, 1));
               PACE_THIRD: rsp_tready <= (third == 0);
               default:    rsp_tready <= 1'b0;
            endcase
         end
      end
   end

   // Stimulus and end of run
   initial begin : run_stimulus
      int unsigned i;
      int unsigned k;
      int unsigned seq_idx;
      int unsigned pick;
      cmd_type     op;
      logic [7:0]  tx;
      logic        sack;
      result_type  released_idle;
      released_idle = mk_rsp(1'b1, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0);

      // Reset state, spare codes, start/stop/restart, commands rejected while busy
      plan[0]  = mk_row(CMD_TICK,    8'h00, 1'b0, 1'b0, 1, 1'b1, released_idle);
      plan[1]  = mk_row(CMD_SPARE_B, 8'hFF, 1'b1, 1'b1, 1, 1'b1, released_idle);
      plan[2]  = mk_row(CMD_SPARE_A, 8'h00, 1'b0, 1'b0, 1, 1'b1, released_idle);
      plan[3]  = mk_row(CMD_START,   8'h5A, 1'b1, 1'b1, 1, 1'b1,
                        mk_rsp(1'b1, 1'b1, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0));
      plan[4]  = mk_row(CMD_WRITE,   8'hFF, 1'b1, 1'b0, 1, 1'b1,
                        mk_rsp(1'b1, 1'b1, 1'b0, 8'h00, 1'b1, 1'b1, 1'b1));
      plan[5]  = mk_row(CMD_TICK,    8'h00, 1'b0, 1'b1, 3, 1'b0, '0);
      plan[6]  = mk_row(CMD_TICK,    8'hFF, 1'b1, 1'b0, 1, 1'b1,
                        mk_rsp(1'b0, 1'b0, 1'b1, 8'h00, 1'b1, 1'b0, 1'b0));
      plan[7]  = mk_row(CMD_STOP,    8'h00, 1'b0, 1'b0, 1, 1'b1,
                        mk_rsp(1'b0, 1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0));
      plan[8]  = mk_row(CMD_READ,    8'hA5, 1'b1, 1'b1, 1, 1'b1,
                        mk_rsp(1'b0, 1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 1'b1));
      plan[9]  = mk_row(CMD_TICK,    8'h00, 1'b0, 1'b0, 2, 1'b0, '0);
      plan[10] = mk_row(CMD_TICK,    8'h00, 1'b0, 1'b1, 1, 1'b1,
                        mk_rsp(1'b1, 1'b1, 1'b1, 8'h00, 1'b1, 1'b0, 1'b0));
      plan[11] = mk_row(CMD_RSTART,  8'h00, 1'b0, 1'b1, 1, 1'b1,
                        mk_rsp(1'b1, 1'b0, 1'b0, 8'h00, 1'b1, 1'b1, 1'b0));
      plan[12] = mk_row(CMD_SPARE_B, 8'h00, 1'b0, 1'b0, 3, 1'b0, '0);
      plan[13] = mk_row(CMD_TICK,    8'h00, 1'b0, 1'b1, 4, 1'b0, '0);
      plan[14] = mk_row(CMD_TICK,    8'h00, 1'b0, 1'b0, 1, 1'b1,
                        mk_rsp(1'b0, 1'b0, 1'b1, 8'h00, 1'b1, 1'b0, 1'b0));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIRECTED_ROWS; i++)
         repeat (plan[i].reps)
            offer(plan[i].code, plan[i].tx, plan[i].sack, plan[i].sda, plan[i].fixed,
                  plan[i].want);

      // Random command runs; the first four hit the byte and ack extremes
      items_sent = 0;
      seq_idx    = 0;
      while (items_sent < RANDOM_ITEMS) begin
         tx   = 8'($urandom_range(0, 255));
         sack = 1'($urandom_range(0, 1));
         case (seq_idx)
            0: begin op = CMD_WRITE; tx = 8'hFF; end
            1: begin op = CMD_WRITE; tx = 8'h00; end
            2: begin op = CMD_READ;  sack = 1'b1; end
            3: begin op = CMD_READ;  sack = 1'b0; end
            default: begin
               pick = $urandom_range(0, 9);
               if (pick == 0)      op = CMD_START;
               else if (pick == 1) op = CMD_RSTART;
               else if (pick == 2) op = CMD_STOP;
               else if (pick <= 6) op = CMD_WRITE;
               else                op = CMD_READ;
            end
         endcase
         offer(op, tx, sack, 1'($urandom_range(0, 1)), 1'b0, '0);
         for (k = 0; k < half_periods(op); k++) begin
            // Drop in a command while busy now and then; it must be rejected
            if ($urandom_range(0, 19) == 0)
               offer(3'($urandom_range(CMD_START, CMD_READ)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
            offer_tick();
         end
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) offer_tick();
         seq_idx++;
      end
      req_tvalid <= 1'b0;

      // Drain outstanding beats, then watch for strays
      while (levels_due_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

[i2c_master_bit_engine.f]
hdl/i2cm_pkg.sv
hdl/i2cm_front.sv
hdl/i2cm_queue.sv
hdl/i2cm_back.sv
hdl/i2c_master_bit_engine.sv
verif/tb.sv
